// ===== hw/rtl/bms_pkg.sv =====
// Shared types and constants for the block median select design.
package bms_pkg;

   localparam int DATA_W           = 32;
   localparam int SET_SIZE_W       = 5;
   localparam int CAPACITY_DEFAULT = 16;

   localparam logic [SET_SIZE_W-1:0] SET_SIZE_RESET = SET_SIZE_W'(11);

   // Set sequencer states
   typedef enum logic [1:0] {
      ST_LOAD,
      ST_PICK,
      ST_CALC
   } seq_state_type;

   // Control broadcast to every cell of the sorting chain
   typedef struct packed {
      logic insert;
      logic restart;
   } cell_ctrl_type;

endpackage

// ===== hw/rtl/bms_cell.sv =====
// One compare-and-shift cell of the sorted insertion chain.
module bms_cell #(
   parameter int INDEX = 0,
   parameter int CNT_W = 5
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  bms_pkg::cell_ctrl_type               ctrl,
   input  logic signed [bms_pkg::DATA_W-1:0]    sample,
   input  logic                                 prev_le,
   input  logic                                 prev_occ,
   input  logic signed [bms_pkg::DATA_W-1:0]    prev_value,
   input  logic [CNT_W-1:0]                     half,
   output logic                                 le,
   output logic                                 occ,
   output logic signed [bms_pkg::DATA_W-1:0]    value,
   output logic [bms_pkg::DATA_W-1:0]           hi_part,
   output logic [bms_pkg::DATA_W-1:0]           lo_part
);
   import bms_pkg::*;

   logic signed [DATA_W-1:0] value_ff;
   logic signed [DATA_W-1:0] value_in;
   logic                     occ_ff;
   logic                     occ_in;
   logic                     hi_sel;
   logic                     lo_sel;

   // Keep the held value when it does not exceed the new sample
   assign le = occ_ff && (value_ff <= sample);

   // Keep, take the sample at the insert point, or shift in from the left
   always_comb begin
      priority if (le) begin
         value_in = value_ff;
      end else if (prev_le) begin
         value_in = sample;
      end else begin
         value_in = prev_value;
      end
   end

   // Occupancy grows by one cell per insert; drop it when a set completes
   always_comb begin
      priority if (ctrl.restart) begin
         occ_in = 1'b0;
      end else begin
         occ_in = occ_ff || prev_occ;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 1'b0;
      end else if (ctrl.insert) begin
         occ_ff <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.insert) begin
         value_ff <= value_in;
      end
   end

   // Offer the held value when this cell holds a middle element
   assign hi_sel  = (half == CNT_W'(INDEX));
   assign lo_sel  = (half == CNT_W'(INDEX + 1));
   assign hi_part = hi_sel ? value_ff : '0;
   assign lo_part = lo_sel ? value_ff : '0;

   assign occ   = occ_ff;
   assign value = value_ff;

endmodule

// ===== hw/rtl/block_median_select_top.sv =====
// Top level of the block median select: sorting chain, set sequencer and median output.
// The median passes the pick state, the calc state and the output register after a set's last
// sample is transferred. Throughput: one sample per cycle while a set fills; each completed set
// passes the pick state (middle elements) and calc state (sum and halve) with no sample taken,
// longer while the last median is stalled. The CAPACITY compare-and-shift cells insert per cycle.
// Reset (synchronous, active high) empties the set, sets set_size to 11, drops the result.
module block_median_select_top #(
   parameter int CAPACITY = bms_pkg::CAPACITY_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic signed [bms_pkg::DATA_W-1:0]       req_sample,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [bms_pkg::DATA_W-1:0]       rsp_median,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [bms_pkg::SET_SIZE_W-1:0]          csr_set_size
);
   import bms_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int SZ_W  = (CNT_W > SET_SIZE_W) ? CNT_W : SET_SIZE_W;

   seq_state_type                state_ff;
   seq_state_type                state_in;
   logic [SET_SIZE_W-1:0]        set_size_ff;
   logic [CNT_W-1:0]             count_ff;
   logic [CNT_W-1:0]             count_in;
   logic [CNT_W-1:0]             half_ff;
   logic                         odd_ff;
   logic [DATA_W-1:0]            hi_ff;
   logic [DATA_W-1:0]            lo_ff;
   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   logic signed [DATA_W-1:0]     median_ff;
   logic signed [DATA_W-1:0]     median_in;

   logic                         req_xfer;
   logic                         set_done;
   logic                         out_free;
   logic                         load_out;
   logic [SZ_W-1:0]              size_ext;
   logic [SZ_W-1:0]              eff_size;
   logic [SZ_W-1:0]              count_next_ext;
   cell_ctrl_type                cell_ctrl;

   logic [CAPACITY:0]                      le_chain;
   logic [CAPACITY:0]                      occ_chain;
   logic signed [DATA_W-1:0]               value_chain [CAPACITY+1];
   logic [DATA_W-1:0]                      hi_parts [CAPACITY];
   logic [DATA_W-1:0]                      lo_parts [CAPACITY];
   logic [DATA_W-1:0]                      hi_pick;
   logic [DATA_W-1:0]                      lo_pick;
   logic signed [DATA_W:0]                 pair_sum;
   logic signed [DATA_W:0]                 pair_adj;

   // Configuration register: always ready; the user writes it only while idle, unchecked by the block
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         set_size_ff <= SET_SIZE_RESET;
      end else if (csr_valid && csr_ready) begin
         set_size_ff <= csr_set_size;
      end
   end

   // Clamp set size to 1..CAPACITY and test for a completed set
   assign size_ext       = SZ_W'(set_size_ff);
   assign eff_size       = (size_ext == '0) ? SZ_W'(1)
                         : (size_ext > SZ_W'(CAPACITY)) ? SZ_W'(CAPACITY) : size_ext;
   assign count_next_ext = SZ_W'(count_ff) + SZ_W'(1);
   assign req_xfer       = req_valid && !req_stall;
   assign set_done       = (count_next_ext >= eff_size);
   assign out_free       = !rsp_valid_ff || !rsp_stall;

   // Sequencer next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: if (req_xfer && set_done) state_in = ST_PICK;
         ST_PICK: state_in = ST_CALC;
         ST_CALC: if (out_free) state_in = ST_LOAD;
         default: state_in = ST_LOAD;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_stall         = 1'b1;
      load_out          = 1'b0;
      cell_ctrl.insert  = 1'b0;
      cell_ctrl.restart = 1'b0;
      unique case (state_ff)
         ST_LOAD: begin
            req_stall         = 1'b0;
            cell_ctrl.insert  = req_xfer;
            cell_ctrl.restart = set_done;
         end
         ST_PICK: begin
         end
         ST_CALC: begin
            load_out = out_free;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   // Sample count of the current set; capture the middle index on completion
   assign count_in = set_done ? '0 : CNT_W'(count_next_ext);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (req_xfer) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer && set_done) begin
         half_ff <= CNT_W'(count_next_ext >> 1);
         odd_ff  <= count_next_ext[0];
      end
   end

   // Sorting chain: the left edge always admits the sample
   assign le_chain[0]    = 1'b1;
   assign occ_chain[0]   = 1'b1;
   assign value_chain[0] = req_sample;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      bms_cell #(
         .INDEX (i),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (cell_ctrl),
         .sample     (req_sample),
         .prev_le    (le_chain[i]),
         .prev_occ   (occ_chain[i]),
         .prev_value (value_chain[i]),
         .half       (half_ff),
         .le         (le_chain[i+1]),
         .occ        (occ_chain[i+1]),
         .value      (value_chain[i+1]),
         .hi_part    (hi_parts[i]),
         .lo_part    (lo_parts[i])
      );
   end

   // Merge the middle elements offered by the cells
   always_comb begin
      hi_pick = '0;
      lo_pick = '0;
      for (int k = 0; k < CAPACITY; k++) begin
         hi_pick = hi_pick | hi_parts[k];
         lo_pick = lo_pick | lo_parts[k];
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_PICK) begin
         hi_ff <= hi_pick;
         lo_ff <= lo_pick;
      end
   end

   // Full-width sum, halved toward zero for even sets
   assign pair_sum  = $signed({hi_ff[DATA_W-1], hi_ff}) + $signed({lo_ff[DATA_W-1], lo_ff});
   assign pair_adj  = pair_sum + $signed({{DATA_W{1'b0}}, pair_sum[DATA_W]});
   assign median_in = odd_ff ? $signed(hi_ff) : $signed(pair_adj[DATA_W:1]);

   // Output register: hold until the transfer completes
   assign rsp_valid_in = load_out || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         median_ff <= median_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_median = median_ff;

`ifndef SYNTHESIS
   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff < CNT_W'(CAPACITY))
      else $error("sample count reached capacity without completing a set");

   a_set_restart: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && set_done) |=> (count_ff == '0) && (state_ff == ST_PICK))
      else $error("completed set did not restart and move to pick");

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_CALC)
      else $error("result appeared without a median calculation");

   a_no_input_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PICK) |=> !cell_ctrl.insert)
      else $error("sample inserted while a median was being picked");
`endif

endmodule

// ===== dv/block_median_select_top_tb.sv =====
// Self-checking testbench for block_median_select_top: directed and random sample sets.
module block_median_select_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bms_pkg::*;

   localparam int N_SAMPLES   = 1600;
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_WAIT  = 4;
   localparam logic signed [DATA_W-1:0] S_MIN = 32'sh8000_0000;
   localparam logic signed [DATA_W-1:0] S_MAX = 32'sh7FFF_FFFF;

   // Tracks the set being filled and the medians still owed by the block
   class median_scoreboard;
      logic signed [DATA_W-1:0] held_set[$];
      logic signed [DATA_W-1:0] owed_medians[$];
      logic [SET_SIZE_W-1:0]    set_size;
      int                       mismatches;

      function new();
         set_size   = SET_SIZE_RESET;
         mismatches = 0;
      endfunction

      function void take_size(logic [SET_SIZE_W-1:0] v);
         set_size = v;
      endfunction

      // Insert in ascending order (equal values go after), close the set when full
      function void note_sample(logic signed [DATA_W-1:0] x);
         int                       pos;
         int                       fill;
         int                       half;
         longint                   pair_sum;
         logic signed [DATA_W-1:0] med;
         pos = 0;
         while (pos < held_set.size() && held_set[pos] <= x) pos++;
         held_set.insert(pos, x);
         fill = (set_size == 0) ? 1 : (set_size > CAPACITY_DEFAULT) ? CAPACITY_DEFAULT
                                                                  : int'(set_size);
         if (held_set.size() < fill) return;
         half = held_set.size() / 2;
         if (held_set.size() % 2 == 1) begin
            med = held_set[half];
         end else begin
            // full-width sum, halved toward zero
            pair_sum = longint'(held_set[half]) + longint'(held_set[half-1]);
            med      = DATA_W'(pair_sum / 2);
         end
         owed_medians.push_back(med);
         held_set.delete();
      endfunction

      function void check_median(logic signed [DATA_W-1:0] got);
         logic signed [DATA_W-1:0] want;
         if (owed_medians.size() == 0) begin
            $error("median: expected none, actual %0d", got);
            mismatches++;
            return;
         end
         want = owed_medians.pop_front();
         if (got !== want) begin
            $error("median: expected %0d, actual %0d", want, got);
            mismatches++;
         end
      endfunction

      function int owed();
         return owed_medians.size();
      endfunction
   endclass

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic signed [DATA_W-1:0] req_sample;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic signed [DATA_W-1:0] rsp_median;
   logic                     csr_valid;
   logic                     csr_ready;
   logic [SET_SIZE_W-1:0]    csr_set_size;

   median_scoreboard sb = new();
   bit               calm;
   int               cycles = 0;

   block_median_select_top dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_sample   (req_sample),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_median   (rsp_median),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_set_size (csr_set_size)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Observe transfers on every channel; a sample uses the size held before this edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_sample(req_sample);
         if (csr_valid && csr_ready) sb.take_size(csr_set_size);
         if (rsp_valid && !rsp_stall) sb.check_median(rsp_median);
      end
   end

   // Stall the result side at random, except in the calm stretch
   always @(posedge clock) begin
      rsp_stall <= !calm && ($urandom_range(99) < 8);
   end

   // Bound the run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Present one sample, with an occasional gap, and hold it until the transfer
   task automatic send_sample(logic signed [DATA_W-1:0] v);
      int gap;
      if (!calm && $urandom_range(99) < 4) begin
         gap = $urandom_range(3, 1);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= v;
      do @(posedge clock); while (req_stall);
   endtask

   // Drop valid and wait until every owed median has come out
   task automatic drain_medians();
      req_valid <= 1'b0;
      while (sb.owed() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_set_size(logic [SET_SIZE_W-1:0] v);
      csr_valid    <= 1'b1;
      csr_set_size <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   function automatic logic signed [DATA_W-1:0] pick_sample();
      case ($urandom_range(9))
         0:       return S_MIN;
         1:       return S_MAX;
         2, 3, 4: return DATA_W'($signed($urandom_range(8)) - 4);
         5:       return S_MAX - DATA_W'($urandom_range(3));
         6:       return S_MIN + DATA_W'($urandom_range(3));
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [SET_SIZE_W-1:0] pick_set_size();
      case ($urandom_range(7))
         0:       return SET_SIZE_W'(0);
         1:       return SET_SIZE_W'(1);
         2:       return SET_SIZE_W'(2);
         3:       return SET_SIZE_W'(16);
         4:       return SET_SIZE_W'(17);
         5:       return SET_SIZE_W'(31);
         default: return SET_SIZE_W'($urandom_range(31));
      endcase
   endfunction

   initial begin : main
      logic signed [DATA_W-1:0] first_set[11];
      int                       sent;
      int                       run_len;

      first_set = '{S_MAX, S_MIN, 0, -1, 1, S_MAX, S_MIN, 5, 5, -5, 5};
      calm         = 1'b0;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_sample   = '0;
      csr_valid    = 1'b0;
      csr_set_size = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // One set at the reset size, extremes and duplicates
      foreach (first_set[i]) send_sample(first_set[i]);
      drain_medians();

      // Pairs whose sum overflows 32 bits, and a negative odd sum
      write_set_size(SET_SIZE_W'(2));
      send_sample(S_MAX);
      send_sample(S_MAX);
      send_sample(S_MIN);
      send_sample(S_MIN);
      send_sample(-3);
      send_sample(0);
      drain_medians();

      // Size zero behaves as one
      write_set_size(SET_SIZE_W'(0));
      send_sample(123);
      drain_medians();

      // Lower the size mid-set: the next sample closes a set of four
      write_set_size(SET_SIZE_W'(4));
      send_sample(9);
      send_sample(-2);
      send_sample(9);
      drain_medians();
      write_set_size(SET_SIZE_W'(1));
      send_sample(4);
      drain_medians();

      // Random phases, each with its own size; some end mid-set
      sent = 0;
      while (sent < N_SAMPLES) begin
         drain_medians();
         write_set_size(pick_set_size());
         run_len = $urandom_range(150, 20);
         repeat (run_len) begin
            calm = (sent >= 600 && sent < 900);
            send_sample(pick_sample());
            sent++;
         end
      end
      calm = 1'b0;
      drain_medians();

      if (sb.mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
